>>> rtl/core/sliding_median_spike_detector_top_defines.svh
// Assertion macros for the sliding median spike detector.
`ifndef SLIDING_MEDIAN_SPIKE_DETECTOR_TOP_DEFINES_SVH
`define SLIDING_MEDIAN_SPIKE_DETECTOR_TOP_DEFINES_SVH
`define SMSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SMSD_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> rtl/core/smsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median spike detector package
// Shared types and constants.
// ----------------------------------------------------------------------------
package smsd_pkg;
   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned THR_W    = 9;
   localparam int unsigned TOTAL_W  = 32;
   localparam int unsigned LEN_W    = 11;
   localparam logic [LEN_W-1:0] LEN_RESET = 11'd30;

   typedef struct packed {
      logic clear;
      logic shift;
      logic inc;
      logic dec;
   } cell_ctl_type;
endpackage

>>> rtl/core/smsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram bin cell
// Holds one bin count and rotates it to its neighbor in the ring on a shift.
// ----------------------------------------------------------------------------
module smsd_cell
   import smsd_pkg::*;
#(
   parameter int unsigned CNT_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [CNT_W-1:0] prev_cnt,
   output logic [CNT_W-1:0] cnt
);
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.clear) begin
         cnt_in = '0;
      end else if (ctl.shift) begin
         cnt_in = prev_cnt;
      end else if (ctl.inc && !ctl.dec) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (ctl.dec && !ctl.inc && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign cnt = cnt_ff;
endmodule

>>> rtl/core/sliding_median_spike_detector_top.sv
`timescale 1ns / 1ps
// A response follows a req transaction through the states READ, WALK over every
// bin, UPD and OUT while judging, and through READ, UPD and OUT while the window
// fills. One transaction at a time: the next req transaction is taken only after
// the previous response has been accepted; the bin walk rotates the ring of
// histogram cells one bin per cycle. Reset (synchronous, active high)
// clears bins, fill level, position and total and loads a window length of 30.
// ----------------------------------------------------------------------------
// Sliding median spike detector
// Flags samples at or above twice the median of a sliding window.
// ----------------------------------------------------------------------------
`include "sliding_median_spike_detector_top_defines.svh"
module sliding_median_spike_detector_top
   import smsd_pkg::*;
#(
   parameter int unsigned BIN_COUNT  = 256,
   parameter int unsigned WINDOW_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,       // window_length [10:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,      // sample_value [7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata       // window_full, spike_flag, twice_median, spike_total
);
   localparam int unsigned BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int unsigned POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1) + 1;
   localparam int unsigned WALK_W = $clog2(BIN_COUNT + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   eff_len;
   logic [POS_W-1:0]   pos_ff;
   logic [LEN_W-1:0]   fill_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [BIN_W-1:0]   smp_bin;
   logic               full_ff;
   logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
   logic [SAMPLE_W-1:0] oldest_ff;
   logic [BIN_W-1:0]   old_bin;
   logic [WALK_W-1:0]  walk_ff;
   logic [LEN_W-1:0]   sum_ff;
   logic [LEN_W-1:0]   sum_nx;
   logic               have_lo_ff, have_hi_ff;
   logic [BIN_W-1:0]   lo_ff;
   logic [THR_W-1:0]   thr_ff;
   logic               flag_ff;
   logic               rsp_valid_ff;
   logic [LEN_W-1:0]   mid_lo, mid_hi;
   logic [BIN_W-1:0]   walk_bin;
   logic [CNT_W-1:0]   cnt [BIN_COUNT];
   cell_ctl_type       ctl [BIN_COUNT];
   logic [POS_W:0]     pos_nx;

   always_comb begin
      eff_len = len_ff;
      if (len_ff == '0) eff_len = LEN_W'(1);
      if (32'(len_ff) > WINDOW_MAX) eff_len = LEN_W'(WINDOW_MAX);
   end

   function automatic logic [BIN_W-1:0] bin_of(input logic [SAMPLE_W-1:0] v);
      logic [BIN_W-1:0] b;
      if (32'(v) >= BIN_COUNT) b = BIN_W'(BIN_COUNT - 1);
      else b = BIN_W'(v);
      return b;
   endfunction

   assign smp_bin  = bin_of(sample_ff);
   assign old_bin  = bin_of(oldest_ff);
   assign mid_hi   = eff_len >> 1;
   assign mid_lo   = mid_hi - 1'b1;
   assign walk_bin = BIN_W'(walk_ff);
   // Cell 0 always holds the bin currently visited by the walk.
   assign sum_nx   = sum_ff + LEN_W'(cnt[0]);

   genvar gi;
   generate
      for (gi = 0; gi < BIN_COUNT; gi++) begin : g_cell
         always_comb begin
            ctl[gi].clear = csr_valid && csr_ready;
            ctl[gi].shift = (state_ff == ST_WALK);
            ctl[gi].inc   = (state_ff == ST_UPD) && (smp_bin == BIN_W'(gi));
            ctl[gi].dec   = (state_ff == ST_UPD) && full_ff && (old_bin == BIN_W'(gi))
                            && !(smp_bin == BIN_W'(gi) && cnt[gi] == '0);
         end
         smsd_cell #(.CNT_W(CNT_W)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl[gi]),
            .prev_cnt (cnt[(gi + 1) % BIN_COUNT]),
            .cnt      (cnt[gi])
         );
      end
   endgenerate

   assign csr_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff && !csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, total_ff, thr_ff, flag_ff, full_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) state_in = ST_READ;
         ST_READ: state_in = full_ff ? ST_WALK : ST_UPD;
         ST_WALK: if (walk_ff == WALK_W'(BIN_COUNT - 1)) state_in = ST_UPD;
         ST_UPD:  state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign pos_nx = {1'b0, pos_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid && req_tready) begin
         sample_ff <= req_tdata;
      end
      if (state_ff == ST_READ) begin
         oldest_ff <= ring_mem[pos_ff];
      end
      if (state_ff == ST_UPD) begin
         ring_mem[pos_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         pos_ff       <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
         sum_ff       <= '0;
         have_lo_ff   <= 1'b0;
         have_hi_ff   <= 1'b0;
         lo_ff        <= '0;
         thr_ff       <= '0;
         flag_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            len_ff   <= csr_data[LEN_W-1:0];
            pos_ff   <= '0;
            fill_ff  <= '0;
            total_ff <= '0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  full_ff    <= (fill_ff >= eff_len);
                  walk_ff    <= '0;
                  sum_ff     <= '0;
                  have_lo_ff <= 1'b0;
                  have_hi_ff <= 1'b0;
                  lo_ff      <= '0;
                  thr_ff     <= '0;
                  flag_ff    <= 1'b0;
               end
               if (32'(pos_ff) >= 32'(eff_len)) pos_ff <= '0;
            end
            ST_WALK: begin
               walk_ff <= walk_ff + 1'b1;
               sum_ff  <= sum_nx;
               if (eff_len[0]) begin
                  if (!have_hi_ff && sum_nx > mid_hi) begin
                     have_hi_ff <= 1'b1;
                     thr_ff     <= THR_W'({walk_bin, 1'b0});
                  end
               end else begin
                  if (!have_lo_ff && sum_nx > mid_lo) begin
                     have_lo_ff <= 1'b1;
                     lo_ff      <= walk_bin;
                  end
                  if (!have_hi_ff && sum_nx > mid_hi) begin
                     have_hi_ff <= 1'b1;
                     thr_ff     <= THR_W'(THR_W'(have_lo_ff || sum_nx > mid_lo
                                     ? (have_lo_ff ? lo_ff : walk_bin) : walk_bin)
                                   + THR_W'(walk_bin));
                  end
               end
            end
            ST_UPD: begin
               if (full_ff) begin
                  if (THR_W'(sample_ff) >= thr_ff) begin
                     flag_ff <= 1'b1;
                     if (total_ff != '1) total_ff <= total_ff + 1'b1;
                  end
               end else begin
                  fill_ff <= fill_ff + 1'b1;
               end
               if (32'(pos_nx) >= 32'(eff_len)) pos_ff <= '0;
               else pos_ff <= pos_nx[POS_W-1:0];
            end
            ST_OUT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   `SMSD_ASSERT(a_one_txn, clock, reset, (rsp_valid_ff |-> !req_tready),
                "request taken while response pending")
   `SMSD_ASSERT(a_fill_flag, clock, reset,
                (rsp_valid_ff && !full_ff |-> !flag_ff && thr_ff == '0),
                "flag raised during fill")
   `SMSD_ASSERT(a_walk_len, clock, reset, ((state_ff == ST_WALK) |-> full_ff),
                "walk without full window")
   `SMSD_ASSERT_NORST(a_reset_idle, clock,
                      (!reset && $past(reset) |-> state_ff == ST_IDLE && !rsp_valid_ff),
                      "not idle after reset")
endmodule
